// ===== hdl/sbdc_pkg.sv =====
// Shared constants, types and the log2 interpolation table for the spectrum
// bin colour index pipeline. No dependencies.

package sbdc_pkg;

  localparam int PALETTE_SIZE_DEF  = 256;
  localparam int LOG_FRAC_BITS_DEF = 8;

  // Configuration port shape
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 7;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_FFT_SIZE_LOG2   = 2'd0,
    CFG_INPUT_FRAC_BITS = 2'd1,
    CFG_FLOOR_DB        = 2'd2
  } cfg_index_t;

  localparam logic [4:0] FFT_SIZE_LOG2_RST   = 5'd10;
  localparam logic [4:0] INPUT_FRAC_BITS_RST = 5'd15;
  localparam logic [6:0] FLOOR_DB_RST        = 7'd60;

  // round(65536 * 10*log10(2))
  localparam int DB_PER_LOG2_Q16 = 197283;

  // Valid bit plus a flag that forces the index to zero
  typedef struct packed {
    logic vld;
    logic zero;
  } sbdc_ctl_t;

  // round(65536*log2(1+i/16)), i = 0..16
  function automatic logic [16:0] log2_tab(input logic [4:0] i);
    logic [16:0] v;
    case (i)
      5'd0:    v = 17'd0;
      5'd1:    v = 17'd5732;
      5'd2:    v = 17'd11136;
      5'd3:    v = 17'd16248;
      5'd4:    v = 17'd21098;
      5'd5:    v = 17'd25711;
      5'd6:    v = 17'd30109;
      5'd7:    v = 17'd34312;
      5'd8:    v = 17'd38336;
      5'd9:    v = 17'd42196;
      5'd10:   v = 17'd45904;
      5'd11:   v = 17'd49472;
      5'd12:   v = 17'd52911;
      5'd13:   v = 17'd56229;
      5'd14:   v = 17'd59434;
      5'd15:   v = 17'd62534;
      5'd16:   v = 17'd65536;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/sbdc_ifs.sv =====
// Valid/ready channel interfaces: FFT bin words in, colour index words out.
// Standalone; no package dependency.

interface sbdc_bin_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] bin_real;
  logic signed [31:0] bin_imag;

  modport source (output valid, output bin_real, output bin_imag, input ready);
  modport sink   (input valid, input bin_real, input bin_imag, output ready);
endinterface

interface sbdc_idx_if;
  logic       valid;
  logic       ready;
  logic [7:0] color_index;

  modport source (output valid, output color_index, input ready);
  modport sink   (input valid, input color_index, output ready);
endinterface

// ===== hdl/sbdc_power.sv =====
// Power stage pair: magnitude squares, then their 64-bit sum.
// Depends on sbdc_pkg.

module sbdc_power
  import sbdc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] bin_real,
  input  logic signed [31:0] bin_imag,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [63:0]        power
);

  logic [31:0] re_u, im_u, abs_re, abs_im;
  logic [63:0] sq_re_nxt, sq_im_nxt, power_nxt;
  logic [63:0] sq_re_r, sq_im_r, power_r;
  logic        v1_r, v2_r;
  logic        en1, en2;

  assign en2      = !v2_r || out_ready;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  assign re_u   = bin_real;
  assign im_u   = bin_imag;
  assign abs_re = re_u[31] ? (~re_u + 32'd1) : re_u;
  assign abs_im = im_u[31] ? (~im_u + 32'd1) : im_u;

  assign sq_re_nxt = abs_re * abs_re;
  assign sq_im_nxt = abs_im * abs_im;
  assign power_nxt = sq_re_r + sq_im_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      sq_re_r <= sq_re_nxt;
      sq_im_r <= sq_im_nxt;
    end
    if (en2 && v1_r) begin
      power_r <= power_nxt;
    end
  end

  assign out_valid = v2_r;
  assign power     = power_r;

endmodule

// ===== hdl/sbdc_log2.sv =====
// Fixed-point log2 of the bin power, less the reference level, in four stages.
// Depends on sbdc_pkg (interpolation table, control struct).

module sbdc_log2
  import sbdc_pkg::*;
#(
  parameter int LOG_FRAC_BITS = LOG_FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [63:0]                    power,
  input  logic signed [7:0]              ref_shift,
  output sbdc_ctl_t                      out_ctl,
  input  logic                           out_ready,
  output logic signed [LOG_FRAC_BITS+8:0] x
);

  logic        en1, en2, en3, en4;
  logic        v1_r, v2_r, v3_r, v4_r;
  logic        z1_r, z2_r, z3_r, z4_r;

  // coarse normalise by 16-bit chunks
  logic [1:0]  c_nxt, c_r;
  logic [63:0] n1_nxt, n1_r;

  // fine normalise inside the top chunk
  logic [3:0]  k;
  logic        found;
  logic [63:0] m;
  logic [19:0] mant_nxt, mant_r;
  logic [5:0]  e_nxt, e2_r, e3_r;

  // table interpolation
  logic [16:0] t_lo, t_hi, t_diff;
  logic [28:0] prod_nxt, prod_r;
  logic [15:0] t_lo_r;

  // fraction and reference
  logic [16:0]                       t_sum;
  logic [LOG_FRAC_BITS-1:0]          frac;
  logic signed [8:0]                 e_diff;
  logic signed [LOG_FRAC_BITS+8:0]   x_nxt, x_r;

  assign en4      = !v4_r || out_ready;
  assign en3      = !v3_r || en4;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  always_comb begin
    if (power[63:48] != 16'd0) begin
      c_nxt = 2'd0;
    end else if (power[47:32] != 16'd0) begin
      c_nxt = 2'd1;
    end else if (power[31:16] != 16'd0) begin
      c_nxt = 2'd2;
    end else begin
      c_nxt = 2'd3;
    end
  end
  assign n1_nxt = power << {c_nxt, 4'b0000};

  always_comb begin
    k     = 4'd0;
    found = 1'b0;
    for (int j = 0; j < 16; j++) begin
      if (!found && n1_r[63-j]) begin
        k     = 4'(j);
        found = 1'b1;
      end
    end
  end
  assign m        = n1_r << k;
  assign mant_nxt = m[62:43];
  assign e_nxt    = 6'd63 - {c_r, 4'b0000} - {2'b00, k};

  assign t_lo     = log2_tab({1'b0, mant_r[19:16]});
  assign t_hi     = log2_tab({1'b0, mant_r[19:16]} + 5'd1);
  assign t_diff   = t_hi - t_lo;
  assign prod_nxt = t_diff[12:0] * mant_r[15:0];

  assign t_sum  = {1'b0, t_lo_r} + 17'(prod_r[28:16]);
  assign frac   = t_sum[15 -: LOG_FRAC_BITS];
  assign e_diff = $signed({3'b000, e3_r}) - 9'(ref_shift);
  assign x_nxt  = $signed({e_diff, frac});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      n1_r <= n1_nxt;
      c_r  <= c_nxt;
      z1_r <= (power == 64'd0);
    end
    if (en2 && v1_r) begin
      mant_r <= mant_nxt;
      e2_r   <= e_nxt;
      z2_r   <= z1_r;
    end
    if (en3 && v2_r) begin
      prod_r <= prod_nxt;
      t_lo_r <= t_lo[15:0];
      e3_r   <= e2_r;
      z3_r   <= z2_r;
    end
    if (en4 && v3_r) begin
      x_r  <= x_nxt;
      z4_r <= z3_r;
    end
  end

  assign out_ctl.vld  = v4_r;
  assign out_ctl.zero = z4_r;
  assign x            = x_r;

endmodule

// ===== hdl/sbdc_db.sv =====
// Decibel scaling, floor offset and colormap scaling, three stages.
// Depends on sbdc_pkg (dB constant, control struct).

module sbdc_db
  import sbdc_pkg::*;
#(
  parameter int LOG_FRAC_BITS = LOG_FRAC_BITS_DEF,
  parameter int PALETTE_SIZE  = PALETTE_SIZE_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  sbdc_ctl_t                             in_ctl,
  output logic                                  in_ready,
  input  logic signed [LOG_FRAC_BITS+8:0]       x,
  input  logic [6:0]                            floor_lvl,
  output sbdc_ctl_t                             out_ctl,
  input  logic                                  out_ready,
  output logic [$clog2(PALETTE_SIZE)+8:0]       q
);

  localparam int XW  = LOG_FRAC_BITS + 9;
  localparam int DW  = XW + 19;
  localparam int SW  = DW + 1;
  localparam int NW  = LOG_FRAC_BITS + 25;
  localparam int SH  = LOG_FRAC_BITS + 16;
  localparam int CW  = $clog2(PALETTE_SIZE);
  localparam int CSW = CW + 1;
  localparam int PW  = NW + CSW;
  localparam int QW  = CW + 9;

  localparam logic signed [18:0] DB_K = 19'(DB_PER_LOG2_Q16);
  localparam logic [CSW-1:0]     CS_K = CSW'(PALETTE_SIZE);

  logic                 en1, en2, en3;
  logic                 v1_r, v2_r, v3_r;
  logic                 z1_r, z2_r, z3_r;

  logic signed [DW-1:0] d_nxt, d_r;
  logic [SW-1:0]        den;
  logic signed [SW-1:0] num_nxt;
  logic                 kill_nxt;
  logic [NW-1:0]        num_r;
  logic [PW-1:0]        scaled;
  logic [QW-1:0]        q_r;

  assign en3      = !v3_r || out_ready;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  assign d_nxt = DB_K * x;

  // a non-positive level sits at or below the floor
  assign den      = SW'(floor_lvl) << SH;
  assign num_nxt  = $signed(den) + SW'(d_r);
  assign kill_nxt = z1_r || num_nxt[SW-1] || (num_nxt == '0);

  assign scaled = PW'(num_r) * PW'(CS_K);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_ctl.vld;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_ctl.vld) begin
      d_r  <= d_nxt;
      z1_r <= in_ctl.zero;
    end
    if (en2 && v1_r) begin
      num_r <= num_nxt[NW-1:0];
      z2_r  <= kill_nxt;
    end
    if (en3 && v2_r) begin
      q_r  <= scaled[SH +: QW];
      z3_r <= z2_r;
    end
  end

  assign out_ctl.vld  = v3_r;
  assign out_ctl.zero = z3_r;
  assign q            = q_r;

endmodule

// ===== hdl/sbdc_div.sv =====
// Restoring divide of the scaled level by the floor, one quotient bit per
// stage, with saturation to the top index. Depends on sbdc_pkg.

module sbdc_div
  import sbdc_pkg::*;
#(
  parameter int PALETTE_SIZE = PALETTE_SIZE_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  sbdc_ctl_t                           in_ctl,
  output logic                                in_ready,
  input  logic [$clog2(PALETTE_SIZE)+8:0]     q,
  input  logic [6:0]                          floor_lvl,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [$clog2(PALETTE_SIZE)-1:0]     index
);

  localparam int CW = $clog2(PALETTE_SIZE);
  localparam int QW = CW + 9;
  localparam int LW = CW + 7;
  localparam logic [CW-1:0] IDX_MAX = CW'(PALETTE_SIZE - 1);

  logic [LW-1:0] lim;

  logic          v_in   [CW];
  logic          z_in   [CW];
  logic          s_in   [CW];
  logic [QW-1:0] rem_in [CW];
  logic [CW-1:0] quo_in [CW];
  logic          en     [CW];

  logic          v_r    [CW];
  logic          z_r    [CW];
  logic          s_r    [CW];
  logic [QW-1:0] rem_r  [CW];
  logic [CW-1:0] quo_r  [CW];

  // quotient reaches the top index exactly when q >= floor*(size-1)
  assign lim = LW'(floor_lvl) * LW'(PALETTE_SIZE - 1);

  for (genvar j = 0; j < CW; j++) begin : g_stage
    localparam int B = CW - 1 - j;

    logic [QW-1:0] dvs;
    logic          ge;
    logic [QW-1:0] rem_nxt;
    logic [CW-1:0] quo_nxt;

    if (j == 0) begin : g_first
      assign v_in[j]   = in_ctl.vld;
      assign z_in[j]   = in_ctl.zero;
      assign s_in[j]   = (q >= QW'(lim));
      assign rem_in[j] = q;
      assign quo_in[j] = '0;
    end else begin : g_next
      assign v_in[j]   = v_r[j-1];
      assign z_in[j]   = z_r[j-1];
      assign s_in[j]   = s_r[j-1];
      assign rem_in[j] = rem_r[j-1];
      assign quo_in[j] = quo_r[j-1];
    end

    if (j == CW - 1) begin : g_last
      assign en[j] = !v_r[j] || out_ready;
    end else begin : g_mid
      assign en[j] = !v_r[j] || en[j+1];
    end

    assign dvs     = QW'(floor_lvl) << B;
    assign ge      = (rem_in[j] >= dvs);
    assign rem_nxt = ge ? (rem_in[j] - dvs) : rem_in[j];
    assign quo_nxt = quo_in[j] | (CW'(ge) << B);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (en[j]) begin
        v_r[j] <= v_in[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en[j] && v_in[j]) begin
        z_r[j]   <= z_in[j];
        s_r[j]   <= s_in[j];
        rem_r[j] <= rem_nxt;
        quo_r[j] <= quo_nxt;
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[CW-1];
  assign index     = z_r[CW-1] ? '0 : (s_r[CW-1] ? IDX_MAX : quo_r[CW-1]);

endmodule

// ===== hdl/spectrum_bin_db_colormap_index_top.sv =====
// Top level of the spectrum bin colour index pipeline: configuration
// registers, the four pipeline sections and the output register.
// Depends on sbdc_pkg, sbdc_ifs, sbdc_power, sbdc_log2, sbdc_db, sbdc_div.

// One word on in_bin is a complex FFT bin; one word on out_idx is its
// colormap index. The block takes a word every cycle unless a stalled output
// holds it back, and passes it through 10 + ceil(log2(PALETTE_SIZE)) register
// stages (18 at the default size of 256). Two stages form the power, four
// take the log2 and subtract the reference 0.25*N*N, three scale to decibels
// and onto the colormap, one stage per quotient bit divides by the floor
// level, and a final output register holds the word. Each stage has its own
// valid bit and advances when it is empty or the stage after it moves, so a
// stalled output only holds back as many words as it must and bubbles close
// up. Zero power gives index 0, anything at or above 0 dB saturates to
// PALETTE_SIZE-1, and a floor_db of zero counts as 1. Write configuration
// only while no word is in flight.

module spectrum_bin_db_colormap_index_top
  import sbdc_pkg::*;
#(
  parameter int PALETTE_SIZE  = PALETTE_SIZE_DEF,
  parameter int LOG_FRAC_BITS = LOG_FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  sbdc_bin_if.sink              in_bin,
  sbdc_idx_if.source            out_idx,
  input  logic                  cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CW     = $clog2(PALETTE_SIZE);
  localparam int NSTAGE = CW + 10;
  localparam int OCCW   = $clog2(NSTAGE + 1) + 1;

  // configuration registers
  logic [4:0] fft_size_log2_r;
  logic [4:0] input_frac_bits_r;
  logic [6:0] floor_db_r;

  logic signed [7:0] ref_shift;
  logic [6:0]        floor_lvl;

  // section hand-offs
  logic                            pw_valid, pw_ready;
  logic [63:0]                     power;
  sbdc_ctl_t                       lg_ctl;
  logic                            lg_ready;
  logic signed [LOG_FRAC_BITS+8:0] x;
  sbdc_ctl_t                       db_ctl;
  logic                            db_ready;
  logic [CW+8:0]                   q;
  logic                            dv_valid, dv_ready;
  logic [CW-1:0]                   index;

  // output register
  logic       out_valid_r;
  logic [7:0] color_index_r;

  // words in flight, for checking only
  logic [OCCW-1:0] occ_r, occ_nxt;

  // --------------------------------------------------------------------------
  // Configuration: take a write on any enabled cycle, drop unknown indexes
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fft_size_log2_r   <= FFT_SIZE_LOG2_RST;
      input_frac_bits_r <= INPUT_FRAC_BITS_RST;
      floor_db_r        <= FLOOR_DB_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FFT_SIZE_LOG2:   fft_size_log2_r   <= cfg_data[4:0];
        CFG_INPUT_FRAC_BITS: input_frac_bits_r <= cfg_data[4:0];
        CFG_FLOOR_DB:        floor_db_r        <= cfg_data;
        default: ;
      endcase
    end
  end

  // Reference 0.25*N*N against a power with 2f fraction bits:
  // log2 offset 2f + 2*log2(N) - 2, in whole bits
  assign ref_shift = $signed({2'b00, input_frac_bits_r, 1'b0})
                   + $signed({2'b00, fft_size_log2_r, 1'b0}) - 8'sd2;

  // treat a zero floor as 1 dB
  assign floor_lvl = (floor_db_r == 7'd0) ? 7'd1 : floor_db_r;

  // --------------------------------------------------------------------------
  // Pipeline sections
  // --------------------------------------------------------------------------
  sbdc_power u_power (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_bin.valid),
    .in_ready  (in_bin.ready),
    .bin_real  (in_bin.bin_real),
    .bin_imag  (in_bin.bin_imag),
    .out_valid (pw_valid),
    .out_ready (pw_ready),
    .power     (power)
  );

  sbdc_log2 #(
    .LOG_FRAC_BITS (LOG_FRAC_BITS)
  ) u_log2 (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pw_valid),
    .in_ready  (pw_ready),
    .power     (power),
    .ref_shift (ref_shift),
    .out_ctl   (lg_ctl),
    .out_ready (lg_ready),
    .x         (x)
  );

  sbdc_db #(
    .LOG_FRAC_BITS (LOG_FRAC_BITS),
    .PALETTE_SIZE  (PALETTE_SIZE)
  ) u_db (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ctl    (lg_ctl),
    .in_ready  (lg_ready),
    .x         (x),
    .floor_lvl (floor_lvl),
    .out_ctl   (db_ctl),
    .out_ready (db_ready),
    .q         (q)
  );

  sbdc_div #(
    .PALETTE_SIZE (PALETTE_SIZE)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ctl    (db_ctl),
    .in_ready  (db_ready),
    .q         (q),
    .floor_lvl (floor_lvl),
    .out_valid (dv_valid),
    .out_ready (dv_ready),
    .index     (index)
  );

  // --------------------------------------------------------------------------
  // Output register: load when empty or when the current word is taken;
  // an index above 8 bits keeps its low byte
  // --------------------------------------------------------------------------
  assign dv_ready = !out_valid_r || out_idx.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (dv_ready) begin
      out_valid_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (dv_ready && dv_valid) begin
      color_index_r <= 8'(index);
    end
  end

  assign out_idx.valid       = out_valid_r;
  assign out_idx.color_index = color_index_r;

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  always_comb begin
    occ_nxt = occ_r;
    if (in_bin.valid && in_bin.ready) occ_nxt = occ_nxt + OCCW'(1);
    if (out_idx.valid && out_idx.ready) occ_nxt = occ_nxt - OCCW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  // input back-pressure only ever comes from a stalled output word
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    !in_bin.ready |-> (out_idx.valid && !out_idx.ready))
    else $error("input stalled without a stalled output word");

  // never more words in flight than there are stages
  a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCCW'(NSTAGE))
    else $error("words in flight exceed pipeline depth");

  // an empty pipe shows no output word
  a_empty_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (occ_r == '0) |-> !out_idx.valid)
    else $error("output word with nothing in flight");

endmodule

// ===== dv/sbdc_colour_checker.sv =====
// Scoreboard for the spectrum bin colour index block: watches both channels
// and the register port, predicts each colour index and compares in order.
// Depends on sbdc_pkg and the channel interfaces in sbdc_ifs.

module sbdc_colour_checker
  import sbdc_pkg::*;
#(
  parameter int PALETTE_SIZE  = PALETTE_SIZE_DEF,
  parameter int LOG_FRAC_BITS = LOG_FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  sbdc_bin_if                    bin_mon,
  sbdc_idx_if                    idx_mon,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     mismatches,
  output int                     pending,
  output int                     compared
);

  // log2(1 + i/16) in Q16, i = 0..16
  localparam longint unsigned LOG2_KNOT [17] = '{
    0, 5732, 11136, 16248, 21098, 25711, 30109, 34312, 38336,
    42196, 45904, 49472, 52911, 56229, 59434, 62534, 65536
  };
  // 10*log10(2) in Q16
  localparam longint DB_STEP_Q16 = 197283;

  logic [4:0] fft_log2_q;
  logic [4:0] frac_bits_q;
  logic [6:0] floor_db_q;
  logic [7:0] expected_idx [$];

  // log2 of a non-zero power, LOG_FRAC_BITS fraction bits
  function automatic longint log2_of_power(input logic [63:0] p);
    int              e;
    int              i;
    logic [63:0]     m;
    longint unsigned lo, hi, r, t;
    e = 63;
    while (p[e] == 1'b0) e--;
    m  = p << (63 - e);
    i  = int'(m[62:59]);
    r  = 64'(m[58:43]);
    lo = LOG2_KNOT[i];
    hi = LOG2_KNOT[i + 1];
    t  = lo + (((hi - lo) * r) >> 16);
    return (longint'(e) << LOG_FRAC_BITS) + longint'(t >> (16 - LOG_FRAC_BITS));
  endfunction

  function automatic logic [7:0] predict_color_index(
    input logic signed [31:0] re,
    input logic signed [31:0] im,
    input logic [4:0]         fft_log2,
    input logic [4:0]         frac_bits,
    input logic [6:0]         floor_db
  );
    longint unsigned mag_re, mag_im, power, unum, uden, q;
    longint          lvl, ref_shift, x, den, num;
    mag_re = (re < 0) ? -longint'(re) : longint'(re);
    mag_im = (im < 0) ? -longint'(im) : longint'(im);
    power  = mag_re * mag_re + mag_im * mag_im;
    if (power == 0) return 8'd0;
    lvl       = (floor_db == 7'd0) ? 1 : longint'(floor_db);
    ref_shift = 2 * longint'(frac_bits) + 2 * longint'(fft_log2) - 2;
    x   = log2_of_power(power) - (ref_shift << LOG_FRAC_BITS);
    den = lvl << (16 + LOG_FRAC_BITS);
    num = DB_STEP_Q16 * x + den;
    if (num <= 0) return 8'd0;
    unum = num;
    uden = den;
    q    = unum * 64'(PALETTE_SIZE) / uden;
    if (q > 64'(PALETTE_SIZE - 1)) q = 64'(PALETTE_SIZE - 1);
    return 8'(q);
  endfunction

  always @(posedge clk) begin : watch_words
    logic [7:0] want;
    if (!rst_n) begin
      fft_log2_q  = FFT_SIZE_LOG2_RST;
      frac_bits_q = INPUT_FRAC_BITS_RST;
      floor_db_q  = FLOOR_DB_RST;
      expected_idx.delete();
    end else begin
      // Predict with the settings in force before any write at this edge
      if (bin_mon.valid && bin_mon.ready)
        expected_idx.push_back(predict_color_index(bin_mon.bin_real, bin_mon.bin_imag,
                                                   fft_log2_q, frac_bits_q, floor_db_q));
      if (idx_mon.valid && idx_mon.ready) begin
        if (expected_idx.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected colour index word: expected none, got %0d",
                   $time, idx_mon.color_index);
        end else begin
          want = expected_idx.pop_front();
          compared++;
          if (idx_mon.color_index !== want) begin
            mismatches++;
            $display("%0t: color_index mismatch: expected %0d, got %0d",
                     $time, want, idx_mon.color_index);
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_FFT_SIZE_LOG2:   fft_log2_q  = cfg_data[4:0];
          CFG_INPUT_FRAC_BITS: frac_bits_q = cfg_data[4:0];
          CFG_FLOOR_DB:        floor_db_q  = cfg_data[6:0];
          default: ;
        endcase
      end
    end
    pending = expected_idx.size();
  end

endmodule

// ===== dv/spectrum_bin_db_colormap_index_top_tb.sv =====
// Testbench top for the spectrum bin colour index block: clock, reset,
// register programming, bin stimulus and the verdict.
// Depends on sbdc_pkg, sbdc_ifs, the block itself and sbdc_colour_checker.

module spectrum_bin_db_colormap_index_top_tb;
  import sbdc_pkg::*;

  localparam int HALF_PERIOD  = 6;
  localparam int RESET_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_BINS  = 1750;
  // Pipeline depth is 10 + log2 of the palette size; allow a margin beyond it
  localparam int SETTLE_CYCLES = 40;

  // Index past the register list; writes to it must change nothing
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_INDEX = 2'd3;

  localparam logic signed [31:0] BIN_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] BIN_MIN = 32'sh8000_0000;

  logic                   clk   = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  sbdc_bin_if bin_if ();
  sbdc_idx_if idx_if ();

  int src_idle_pct;
  int snk_idle_pct;
  int mismatches;
  int pending;
  int compared;
  int cycles;
  int bins_sent;
  int settings_used;

  // Settings currently programmed, kept here to aim random bins at the
  // interesting part of the decibel window
  logic [4:0] cur_fft_log2;
  logic [4:0] cur_frac_bits;
  logic [6:0] cur_floor_db;

  always #(HALF_PERIOD) clk = ~clk;

  spectrum_bin_db_colormap_index_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bin    (bin_if),
    .out_idx   (idx_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  sbdc_colour_checker scoreboard (
    .clk        (clk),
    .rst_n      (rst_n),
    .bin_mon    (bin_if),
    .idx_mon    (idx_if),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending),
    .compared   (compared)
  );

  // Receiver: drop ready at random on each falling edge
  always @(negedge clk) begin
    idx_if.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // Present one bin word at a falling edge and hold it until it is taken.
  // Returns at the falling edge after the handshake, valid still high.
  task automatic send_bin(input logic signed [31:0] re, input logic signed [31:0] im);
    while ($urandom_range(99) < src_idle_pct) begin
      bin_if.valid <= 1'b0;
      @(negedge clk);
    end
    bin_if.valid    <= 1'b1;
    bin_if.bin_real <= re;
    bin_if.bin_imag <= im;
    do @(posedge clk); while (!bin_if.ready);
    bins_sent++;
    @(negedge clk);
  endtask

  // Stop sending and hold off until every word in flight has come out
  task automatic drain_pipeline();
    bin_if.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  // Write all three registers back to back; the spare index is optionally
  // hit last with random data. Junk goes in the unused upper data bits.
  task automatic program_regs(input logic [4:0] fft_log2, input logic [4:0] frac_bits,
                              input logic [6:0] floor_db, input bit hit_spare);
    logic [CFG_DATA_W-1:0] word;
    word       = CFG_DATA_W'($urandom);
    word[4:0]  = fft_log2;
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FFT_SIZE_LOG2;
    cfg_data  <= word;
    @(negedge clk);
    word       = CFG_DATA_W'($urandom);
    word[4:0]  = frac_bits;
    cfg_index <= CFG_INPUT_FRAC_BITS;
    cfg_data  <= word;
    @(negedge clk);
    cfg_index <= CFG_FLOOR_DB;
    cfg_data  <= floor_db;
    @(negedge clk);
    if (hit_spare) begin
      cfg_index <= CFG_SPARE_INDEX;
      cfg_data  <= CFG_DATA_W'($urandom);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    @(negedge clk);
    cur_fft_log2  = fft_log2;
    cur_frac_bits = frac_bits;
    cur_floor_db  = floor_db;
    settings_used++;
  endtask

  // Random component whose magnitude has its leading one at bit len-1;
  // len 0 gives zero and len 32 or more a raw 32-bit word
  function automatic logic signed [31:0] component_of_len(input int len);
    logic [31:0] mag;
    if (len <= 0) return 32'sd0;
    if (len >= 32) return $urandom;
    mag = ($urandom & ((32'd1 << (len - 1)) - 32'd1)) | (32'd1 << (len - 1));
    return ($urandom_range(1) == 1) ? -mag : mag;
  endfunction

  task automatic send_random_bin();
    int                 kind;
    int                 len_re, len_im;
    int                 top_len, span;
    logic signed [31:0] re, im;
    kind = int'($urandom_range(99));
    if (kind < 20) begin
      re = $urandom;
      im = $urandom;
    end else if (kind < 55) begin
      re = component_of_len(int'($urandom_range(32)));
      im = component_of_len(int'($urandom_range(32)));
    end else begin
      // Aim near the window: 0 dB sits at a component of 2^(f + log2N - 1)
      top_len = int'(cur_frac_bits) + int'(cur_fft_log2);
      span    = int'(cur_floor_db) / 6 + 2;
      len_re  = top_len - int'($urandom_range(span));
      len_im  = len_re - int'($urandom_range(4));
      if (len_re > 31) len_re = 31;
      if (len_im > 31) len_im = 31;
      re = component_of_len(len_re);
      im = component_of_len(len_im);
      if ($urandom_range(1) == 1) begin
        re = component_of_len(len_im);
        im = component_of_len(len_re);
      end
    end
    if ($urandom_range(9) == 0) begin
      if ($urandom_range(1) == 1) re = 32'sd0;
      else im = 32'sd0;
    end
    send_bin(re, im);
  endtask

  task automatic pick_random_settings();
    logic [4:0] fft_log2, frac_bits;
    logic [6:0] floor_db;
    if ($urandom_range(3) == 0) begin
      // Anything the register widths allow, out of range included
      fft_log2  = 5'($urandom_range(31));
      frac_bits = 5'($urandom_range(31));
      floor_db  = 7'($urandom_range(127));
    end else begin
      fft_log2  = 5'($urandom_range(16, 2));
      frac_bits = 5'($urandom_range(30, 0));
      floor_db  = 7'($urandom_range(120, 1));
    end
    program_regs(fft_log2, frac_bits, floor_db, $urandom_range(3) == 0);
  endtask

  // Idling by progress through the random part: sender light and receiver
  // heavy, then the reverse, then neither
  function automatic void update_idle_mode(input int done);
    if (done < RANDOM_BINS / 3) begin
      src_idle_pct = 33;
      snk_idle_pct = 74;
    end else if (done < (2 * RANDOM_BINS) / 3) begin
      src_idle_pct = 74;
      snk_idle_pct = 33;
    end else begin
      src_idle_pct = 0;
      snk_idle_pct = 0;
    end
  endfunction

  initial begin : stimulus
    int random_done;
    int burst;
    bin_if.valid    = 1'b0;
    bin_if.bin_real = 32'sd0;
    bin_if.bin_imag = 32'sd0;
    idx_if.ready    = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = CFG_FFT_SIZE_LOG2;
    cfg_data        = '0;
    cur_fft_log2    = FFT_SIZE_LOG2_RST;
    cur_frac_bits   = INPUT_FRAC_BITS_RST;
    cur_floor_db    = FLOOR_DB_RST;
    settings_used   = 1;
    random_done     = 0;
    update_idle_mode(0);

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: 0 dB at a component of 2^24, -60 dB near 16777
    send_bin(32'sd0, 32'sd0);              // zero power
    send_bin(32'sd1, 32'sd0);
    send_bin(32'sd0, -32'sd1);
    send_bin(BIN_MAX, BIN_MAX);
    send_bin(BIN_MIN, BIN_MIN);            // largest power, 2^63
    send_bin(BIN_MIN, 32'sd0);
    send_bin(BIN_MAX, BIN_MIN);
    send_bin(32'sh0100_0000, 32'sd0);      // exactly full scale
    send_bin(32'sh00FF_FFFF, 32'sd0);      // just below full scale
    send_bin(32'sd16777, 32'sd0);          // close to the floor
    send_bin(-32'sd16000, 32'sd0);         // just under the floor

    // Smallest in-range settings: 0 dB at power 4, a one-decibel window
    drain_pipeline();
    program_regs(5'd2, 5'd0, 7'd1, 1'b0);
    send_bin(32'sd1, 32'sd1);
    send_bin(32'sd2, 32'sd0);
    send_bin(BIN_MIN, BIN_MIN);

    // Largest in-range settings: reference beyond any reachable power
    drain_pipeline();
    program_regs(5'd16, 5'd30, 7'd120, 1'b0);
    send_bin(BIN_MAX, BIN_MAX);
    send_bin(BIN_MIN, 32'sd0);

    // Zero registers: floor level of zero counts as 1, negative reference
    drain_pipeline();
    program_regs(5'd0, 5'd0, 7'd0, 1'b1);
    send_bin(32'sd1, 32'sd0);
    send_bin(32'sd0, 32'sd0);

    // All-ones registers, beyond the stated ranges
    drain_pipeline();
    program_regs(5'd31, 5'd31, 7'd127, 1'b0);
    send_bin(BIN_MIN, BIN_MIN);
    send_bin(32'sd1, 32'sd1);

    // Random part: a fresh setting per burst, reprogrammed only when idle
    while (random_done < RANDOM_BINS) begin
      drain_pipeline();
      pick_random_settings();
      burst = int'($urandom_range(220, 60));
      while (burst > 0 && random_done < RANDOM_BINS) begin
        update_idle_mode(random_done);
        send_random_bin();
        random_done++;
        burst--;
        // Now and then hold the sender until the pipeline is empty
        if ($urandom_range(149) == 0) drain_pipeline();
      end
    end

    drain_pipeline();
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Sent %0d bins under %0d register settings, %0d colour indices compared.",
             bins_sent, settings_used, compared);
    $display("Covered zero power, saturation at both ends, zero floor and all-ones registers.");
    if (mismatches == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches, %0d words still expected", mismatches, pending);
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog: end the run if the pipeline or the handshake hangs
  initial begin : watchdog
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Run stopped after %0d cycles without finishing", cycles);
    $display("FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/sbdc_pkg.sv
hdl/sbdc_ifs.sv
hdl/sbdc_power.sv
hdl/sbdc_log2.sv
hdl/sbdc_db.sv
hdl/sbdc_div.sv
hdl/spectrum_bin_db_colormap_index_top.sv
dv/sbdc_colour_checker.sv
dv/spectrum_bin_db_colormap_index_top_tb.sv
